/* rtl/core/ttli_pkg.sv */
// Shared types and constants of the time table linear interpolator.
`default_nettype none
package ttli_pkg;
    localparam logic [1:0] FUNC_TIME  = 2'd0;
    localparam logic [1:0] FUNC_VALUE = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_INTERP   = 2'd0;
    localparam logic [1:0] ST_EXACT    = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    localparam logic [2:0] ADDR_NUM_POINTS   = 3'd0;
    localparam logic [2:0] ADDR_NUM_CHANNELS = 3'd4;

    localparam int MAX_RESULTS = 8;

    // One item as it travels from the front end to the back end.
    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  index;
        logic [2:0]  channel;
        logic [31:0] data;
    } t_item;
endpackage
`default_nettype wire

/* rtl/core/ttli_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ttli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/core/ttli_front.sv */
// Front end: accepts items, drops ignored ones and queues the rest.
`default_nettype none
module ttli_front import ttli_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_item       i_item,
    output logic             o_q_valid,
    input  wire logic        i_q_pop,
    output t_item            o_q_item
);
    localparam int QD = 4;
    t_item      r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push, w_keep;

    assign o_stall   = (r_cnt == 3'(QD));
    assign w_keep    = (i_item.func != FUNC_NONE);
    assign w_push    = i_valid && !o_stall && w_keep;
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (i_q_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(i_q_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/core/ttli_back.sv */
// Back end: table stores, cursor walk, serial divider and result register.
`default_nettype none
module ttli_back import ttli_pkg::*; #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [10:0] i_num_points,
    input  wire logic [3:0]  i_num_channels,
    input  wire logic        i_q_valid,
    output logic             o_q_pop,
    input  wire t_item       i_q_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_out_channel,
    output logic [31:0]      o_value,
    output logic [1:0]       o_status,
    output logic             o_last
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int VD  = TABLE_DEPTH * MAX_CHANNELS;
    localparam int VAW = $clog2(VD);
    localparam int NMAX = (MAX_CHANNELS < MAX_RESULTS) ? MAX_CHANNELS : MAX_RESULTS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_CH    = 4'd4;
    localparam logic [3:0] S_U1    = 4'd5;
    localparam logic [3:0] S_U2    = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_T0    = 4'd11;
    localparam logic [3:0] S_T0W   = 4'd12;

    localparam logic [1:0] M_INACTIVE = 2'd0;
    localparam logic [1:0] M_EXACT    = 2'd1;
    localparam logic [1:0] M_INTERP   = 2'd2;

    logic [3:0]  r_state;
    t_item       r_it;
    logic [AW-1:0] r_cur, r_i;
    logic [16:0] r_n;
    logic [3:0]  r_nch, r_k;
    logic signed [31:0] r_t1, r_t2, r_u1, r_u2;
    logic        r_t1ok;
    logic [1:0]  r_mode;
    logic [AW-1:0] r_row;
    logic [1:0]  r_st;
    logic [63:0] r_p, r_rem;
    logic [32:0] r_w;
    logic [6:0]  r_bit;
    logic [63:0] r_q;
    logic        r_neg;
    logic signed [32:0] r_d, r_e;

    // Time store: read address chosen by the walker.
    logic          w_twe, w_vwe;
    logic [AW-1:0] r_traddr;
    logic [31:0]   w_trd, w_vrd;
    logic [VAW-1:0] r_vraddr;

    assign w_twe = (r_state == S_IDLE) && i_q_valid && (i_q_item.func == FUNC_TIME)
                   && ({22'd0, i_q_item.index} < 32'(TABLE_DEPTH));
    assign w_vwe = (r_state == S_IDLE) && i_q_valid && (i_q_item.func == FUNC_VALUE)
                   && ({22'd0, i_q_item.index} < 32'(TABLE_DEPTH))
                   && ({29'd0, i_q_item.channel} < 32'(MAX_CHANNELS));

    ttli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_time (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(AW'(i_q_item.index)),
        .i_wdata(i_q_item.data), .i_raddr(r_traddr), .o_rdata(w_trd));

    logic [VAW-1:0] w_vwaddr;
    assign w_vwaddr = VAW'(({22'd0, i_q_item.index} * 32'(MAX_CHANNELS))
                           + {29'd0, i_q_item.channel});
    ttli_ram #(.WIDTH(32), .DEPTH(VD)) u_val (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vwaddr),
        .i_wdata(i_q_item.data), .i_raddr(r_vraddr), .o_rdata(w_vrd));

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    logic signed [31:0] w_x;
    assign w_x = r_it.data;
    logic [16:0] w_nclamp;
    assign w_nclamp = ({6'd0, i_num_points} > 17'(TABLE_DEPTH)) ? 17'(TABLE_DEPTH)
                                                                : {6'd0, i_num_points};
    logic [3:0] w_nch;
    always_comb begin
        w_nch = (i_num_channels == 4'd0) ? 4'd1 : i_num_channels;
        if ({28'd0, w_nch} > 32'(NMAX)) w_nch = 4'(NMAX);
    end

    function automatic logic [VAW-1:0] vaddr(input logic [AW-1:0] row, input logic [3:0] ch);
        vaddr = VAW'(({{(32-AW){1'b0}}, row} * 32'(MAX_CHANNELS)) + {28'd0, ch});
    endfunction

    // Magnitudes fit 32 bits, so the product is a plain 32 by 32 multiply.
    logic [31:0] w_ad, w_ae;
    logic [63:0] w_prod;
    assign w_ad   = r_d[32] ? 32'(-r_d) : r_d[31:0];
    assign w_ae   = r_e[32] ? 32'(-r_e) : r_e[31:0];
    assign w_prod = w_ad * w_ae;

    logic signed [65:0] w_sum;
    logic [63:0] w_off;
    logic [64:0] w_trial;
    assign w_off   = (r_q > 64'h4_0000_0000) ? 64'h4_0000_0000 : r_q;
    assign w_sum   = r_neg ? (66'(r_u1) - $signed({2'b00, w_off}))
                           : (66'(r_u1) + $signed({2'b00, w_off}));
    assign w_trial = {r_rem, r_p[63]} ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_q_valid && i_q_item.func == FUNC_QUERY) begin
                    r_it  <= i_q_item;
                    r_n   <= w_nclamp;
                    r_nch <= w_nch;
                    r_k   <= '0;
                    if (w_nclamp == 17'd0) begin
                        r_mode  <= M_INACTIVE;
                        r_state <= S_CH;
                    end else if (w_nclamp == 17'd1) begin
                        r_traddr <= '0;
                        r_state  <= S_T0;
                    end else begin
                        if ({{(17-AW){1'b0}}, r_cur} > w_nclamp - 17'd2) begin
                            r_i <= AW'(w_nclamp - 17'd2);
                            r_traddr <= AW'(w_nclamp - 17'd2);
                        end else begin
                            r_i <= r_cur;
                            r_traddr <= r_cur;
                        end
                        r_state <= S_RD1;
                    end
                end
                S_T0: r_state <= S_T0W;
                S_T0W: begin
                    r_mode  <= M_EXACT;
                    r_row   <= '0;
                    r_st    <= (w_x == $signed(w_trd)) ? ST_EXACT : ST_INTERP;
                    r_state <= S_CH;
                end
                S_RD1: begin
                    r_traddr <= r_i + AW'(1);
                    r_state  <= S_RD2;
                end
                S_RD2: begin
                    r_t1    <= w_trd;
                    r_state <= S_WALK;
                    r_t1ok  <= 1'b0;
                end
                S_WALK: begin
                    // One bracketing step per read pair; t2 arrives here.
                    if (!r_t1ok) begin
                        r_t2 <= w_trd;
                        r_t1ok <= 1'b1;
                    end else begin
                        if (r_i != '0 && w_x < r_t1) begin
                            r_i <= r_i - AW'(1);
                            r_traddr <= r_i - AW'(1);
                            r_state <= S_RD1;
                        end else if (w_x > r_t2 &&
                                     {{(17-AW){1'b0}}, r_i} + 17'd2 < r_n) begin
                            r_i <= r_i + AW'(1);
                            r_traddr <= r_i + AW'(1);
                            r_state <= S_RD1;
                        end else begin
                            r_cur <= r_i;
                            if (w_x == r_t1 || w_x == r_t2) begin
                                r_mode <= M_EXACT;
                                r_st   <= ST_EXACT;
                                r_row  <= (w_x == r_t1) ? r_i : r_i + AW'(1);
                            end else begin
                                r_mode <= M_INTERP;
                                r_st   <= ST_INTERP;
                            end
                            r_state <= S_CH;
                        end
                    end
                end
                S_CH: begin
                    if (r_mode == M_INACTIVE) begin
                        o_out_channel <= r_k[2:0];
                        o_value  <= '0;
                        o_status <= ST_INACTIVE;
                        o_last   <= (r_k + 4'd1 == r_nch);
                        r_state  <= S_OUT;
                        o_valid  <= 1'b1;
                    end else begin
                        r_vraddr <= vaddr((r_mode == M_EXACT) ? r_row : r_i, r_k);
                        r_state  <= S_U1;
                    end
                end
                S_U1: begin
                    r_vraddr <= vaddr(r_i + AW'(1), r_k);
                    r_state  <= S_U2;
                end
                S_U2: begin
                    r_u1 <= w_vrd;
                    if (r_mode == M_EXACT) begin
                        o_out_channel <= r_k[2:0];
                        o_value  <= w_vrd;
                        o_status <= r_st;
                        o_last   <= (r_k + 4'd1 == r_nch);
                        o_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_u2 <= w_vrd;
                    r_d  <= 33'($signed(w_vrd)) - 33'(r_u1);
                    r_e  <= 33'(w_x) - 33'(r_t1);
                    r_w  <= 33'(r_t2) - 33'(r_t1);
                    r_state <= S_DIV;
                    r_bit <= 7'd127;
                end
                S_DIV: begin
                    if (r_bit == 7'd127) begin
                        if (r_w == 33'd0 || r_u1 == r_u2) begin
                            r_q <= '0;
                            r_neg <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_neg <= r_d[32] ^ r_e[32] ^ r_w[32];
                            r_p <= w_prod;
                            r_w <= r_w[32] ? -r_w : r_w;
                            r_rem <= '0;
                            r_q <= '0;
                            r_bit <= 7'd64;
                        end
                    end else if (r_bit != 7'd0) begin
                        // Restoring division, one quotient bit per cycle.
                        if (w_trial >= {32'd0, r_w}) begin
                            r_rem <= 64'(w_trial - {32'd0, r_w});
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= w_trial[63:0];
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                        r_p   <= {r_p[62:0], 1'b0};
                        r_bit <= r_bit - 7'd1;
                    end else begin
                        if (r_neg && r_rem != 64'd0) r_q <= r_q + 64'd1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_out_channel <= r_k[2:0];
                    if (w_sum > 66'sh7FFF_FFFF) o_value <= 32'h7FFF_FFFF;
                    else if (w_sum < -66'sh8000_0000) o_value <= 32'h8000_0000;
                    else o_value <= w_sum[31:0];
                    o_status <= ST_INTERP;
                    o_last   <= (r_k + 4'd1 == r_nch);
                    o_valid  <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: if (!o_valid || !i_stall) begin
                    if (o_valid && !i_stall) begin
                        if (r_k + 4'd1 == r_nch) r_state <= S_IDLE;
                        else begin
                            r_k <= r_k + 4'd1;
                            r_state <= S_CH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/time_table_linear_interpolator_core.sv */
// Top level of the time table linear interpolator.
// Input items: func 0 loads a breakpoint time, func 1 loads a channel value,
// func 2 queries. A query answers one transfer per channel, in channel order,
// with last high on the final one. Load items give no result.
// Items enter a four-entry queue; the back end takes one at a time.
// Loads are taken by the back end in its idle state. A query first walks the
// cursor to bracket the time (skipped for a single point or an empty
// table), then per channel gives an inactive answer, an exact one, or an
// interpolated one from a bit-serial divider; a zero-width segment or
// equal values skip the divider.
// After reset the cursor is row 0, num_points is 0 (all queries answer
// inactive) and num_channels is 1. Table memories are undefined until loaded.
// While the receiver holds i_stall high, the result register holds its
// transfer and the back end waits; the queue keeps taking items until full.
// Registers: num_points at byte 0, num_channels at byte 4.
`default_nettype none
module time_table_linear_interpolator_core import ttli_pkg::*; #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [9:0]  i_index,
    input  wire logic [2:0]  i_channel,
    input  wire logic [31:0] i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_out_channel,
    output logic [31:0]      o_value,
    output logic [1:0]       o_status,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [10:0] r_num_points;
    logic [3:0]  r_num_channels;
    t_item       w_item, w_qitem;
    logic        w_qv, w_pop;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= '0;
            r_num_channels <= 4'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_NUM_POINTS) r_num_points <= pwdata[10:0];
            else if (paddr == ADDR_NUM_CHANNELS) r_num_channels <= pwdata[3:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_NUM_POINTS) prdata = {21'd0, r_num_points};
        else if (paddr == ADDR_NUM_CHANNELS) prdata = {28'd0, r_num_channels};
    end

    assign w_item = '{func: i_func, index: i_index, channel: i_channel, data: i_data};

    ttli_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(w_item), .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_item(w_qitem));

    ttli_back #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num_points(r_num_points),
        .i_num_channels(r_num_channels), .i_q_valid(w_qv), .o_q_pop(w_pop),
        .i_q_item(w_qitem), .o_valid(o_valid), .i_stall(i_stall),
        .o_out_channel(o_out_channel), .o_value(o_value), .o_status(o_status),
        .o_last(o_last));
endmodule
`default_nettype wire
